// File: hw/rtl/bpw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Banked pixel writer package
// Shared widths, format and opcode codes, register indexes and the structs
// that travel between the palette unit, the address unit and the top level.
// ----------------------------------------------------------------------------
package bpw_pkg;

    // Field widths of one input word
    localparam int FIELD_COORD_W = 12;
    localparam int COLOR_W       = 8;
    localparam int PAL_IDX_W     = 4;
    localparam int PAL_COMP_W    = 6;
    localparam int PAL_ENTRY_W   = 3 * PAL_COMP_W;
    localparam int PAL_ENTRIES   = 16;

    // Field widths of one result word
    localparam int BANK_W  = 16;
    localparam int OFFS_W  = 16;
    localparam int DATA_W  = 24;
    localparam int COUNT_W = 2;

    // Stream widths
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 64;

    // Configuration register widths
    localparam int FMT_W      = 3;
    localparam int WIDTH_W    = 13;
    localparam int LINE_W     = 15;
    localparam int WSHIFT_W   = 5;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 15;

    // Default coordinate width
    localparam int COORD_BITS_DEF = 12;

    // Window shift limits
    localparam logic [WSHIFT_W-1:0] WSHIFT_MIN = 5'd10;
    localparam logic [WSHIFT_W-1:0] WSHIFT_MAX = 5'd16;

    // Pixel format codes
    localparam logic [FMT_W-1:0] FMT_4BPP  = 3'd0;
    localparam logic [FMT_W-1:0] FMT_8BPP  = 3'd1;
    localparam logic [FMT_W-1:0] FMT_15BPP = 3'd2;
    localparam logic [FMT_W-1:0] FMT_16BPP = 3'd3;
    localparam logic [FMT_W-1:0] FMT_24BPP = 3'd4;
    localparam logic [FMT_W-1:0] FMT_32BPP = 3'd5;
    localparam logic [FMT_W-1:0] FMT_LAST  = FMT_32BPP;

    // Opcodes
    localparam logic OP_PIXEL   = 1'b0;
    localparam logic OP_PALETTE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_PIXEL_FORMAT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SCREEN_WIDTH = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_LINE_BYTES   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_SHIFT = 2'd3;

    // Reset values of the configuration registers
    localparam logic [FMT_W-1:0]    FMT_RST    = FMT_8BPP;
    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 13'd640;
    localparam logic [LINE_W-1:0]   LINE_RST   = 15'd320;
    localparam logic [WSHIFT_W-1:0] WSHIFT_RST = 5'd16;

    // Byte counts
    localparam logic [COUNT_W-1:0] COUNT_ONE   = 2'd1;
    localparam logic [COUNT_W-1:0] COUNT_TWO   = 2'd2;
    localparam logic [COUNT_W-1:0] COUNT_THREE = 2'd3;

    // Palette entry write request
    typedef struct packed {
        logic                   en;
        logic [PAL_IDX_W-1:0]   idx;
        logic [PAL_ENTRY_W-1:0] entry;
    } pal_wr_t;

    // Bytes to store for one pixel
    typedef struct packed {
        logic [DATA_W-1:0]  data;
        logic [COUNT_W-1:0] count;
    } pix_data_t;

    // Bank and offset of one pixel
    typedef struct packed {
        logic [BANK_W-1:0] bank;
        logic [OFFS_W-1:0] offset;
    } pix_addr_t;

endpackage

// File: hw/rtl/bpw_palette.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Banked pixel writer palette unit
// Holds the 16-entry RGB palette, takes entry writes and expands a pixel
// color into the bytes to store for the current pixel format.
// ----------------------------------------------------------------------------
module bpw_palette (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bpw_pkg::pal_wr_t              pal_wr,
    input  logic [bpw_pkg::COLOR_W-1:0]   color,
    input  logic [bpw_pkg::FMT_W-1:0]     pixel_format,
    output bpw_pkg::pix_data_t            pix_data
);

    logic [bpw_pkg::PAL_ENTRY_W-1:0] pal_mem_reg [bpw_pkg::PAL_ENTRIES];

    logic [bpw_pkg::COLOR_W-1:0]     idx_adj;
    logic [bpw_pkg::PAL_IDX_W-1:0]   rd_idx;
    logic [bpw_pkg::PAL_ENTRY_W-1:0] entry;
    logic [bpw_pkg::PAL_COMP_W-1:0]  red, green, blue;
    logic                            above_seven;

    // Palette storage, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < bpw_pkg::PAL_ENTRIES; i++) begin
                pal_mem_reg[i] <= '0;
            end
        end else if (pal_wr.en) begin
            pal_mem_reg[pal_wr.idx] <= pal_wr.entry;
        end
    end

    // Read index: the 15/16 bpp formats index with color minus seven above seven
    assign above_seven = (color > 8'd7);
    assign idx_adj     = above_seven ? (color - 8'd7) : color;

    always_comb begin
        if (pixel_format == bpw_pkg::FMT_24BPP || pixel_format == bpw_pkg::FMT_32BPP) begin
            rd_idx = color[bpw_pkg::PAL_IDX_W-1:0];
        end else begin
            rd_idx = idx_adj[bpw_pkg::PAL_IDX_W-1:0];
        end
    end

    assign entry = pal_mem_reg[rd_idx];
    assign red   = entry[17:12];
    assign green = entry[11:6];
    assign blue  = entry[5:0];

    // Expand the entry into the stored bytes
    always_comb begin
        case (pixel_format)
            bpw_pkg::FMT_15BPP: begin
                pix_data.data  = {9'd0, red[4:0], green[4:0], blue[4:0]};
                pix_data.count = bpw_pkg::COUNT_TWO;
            end
            bpw_pkg::FMT_16BPP: begin
                if (above_seven) begin
                    pix_data.data = {9'd0, red[3:0], 1'b0, green[3:0], 1'b0,
                                     blue[3:0], 1'b0};
                end else begin
                    pix_data.data = {9'd0, red[4:0], green[4:0], blue[4:0]};
                end
                pix_data.count = bpw_pkg::COUNT_TWO;
            end
            bpw_pkg::FMT_24BPP, bpw_pkg::FMT_32BPP: begin
                pix_data.data  = {blue, 2'b00, green, 2'b00, red, 2'b00};
                pix_data.count = bpw_pkg::COUNT_THREE;
            end
            default: begin
                pix_data.data  = {16'd0, color};
                pix_data.count = bpw_pkg::COUNT_ONE;
            end
        endcase
    end

endmodule

// File: hw/rtl/bpw_addr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Banked pixel writer address unit
// Forms the pixel byte address from row, column and line geometry, then
// splits it into a window bank number and an offset inside the window.
// ----------------------------------------------------------------------------
module bpw_addr #(
    parameter int COORD_BITS = bpw_pkg::COORD_BITS_DEF
) (
    input  logic [bpw_pkg::FIELD_COORD_W-1:0] pos_x,
    input  logic [bpw_pkg::FIELD_COORD_W-1:0] pos_y,
    input  logic [bpw_pkg::FMT_W-1:0]         pixel_format,
    input  logic [bpw_pkg::WIDTH_W-1:0]       screen_width,
    input  logic [bpw_pkg::LINE_W-1:0]        line_bytes,
    input  logic [bpw_pkg::WSHIFT_W-1:0]      window_shift,
    output bpw_pkg::pix_addr_t                pix_addr
);

    // Coordinates are cut to COORD_BITS, never wider than the field
    localparam int CW     = (COORD_BITS < bpw_pkg::FIELD_COORD_W) ?
                            COORD_BITS : bpw_pkg::FIELD_COORD_W;
    localparam int ADDR_W = CW + bpw_pkg::LINE_W + 1;
    localparam int MASK_W = bpw_pkg::OFFS_W + 1;

    logic [CW-1:0]                 x_c, y_c;
    logic [bpw_pkg::LINE_W-1:0]    row_len;
    logic [ADDR_W-1:0]             prod, lin, addr, addr_shr;
    logic [bpw_pkg::WSHIFT_W-1:0]  sh;
    logic [MASK_W-1:0]             mask;

    assign x_c = pos_x[CW-1:0];
    assign y_c = pos_y[CW-1:0];

    // Row length: line bytes for 4 bpp, pixels per line otherwise
    assign row_len = (pixel_format == bpw_pkg::FMT_4BPP) ? line_bytes :
                     bpw_pkg::LINE_W'(screen_width);

    assign prod = ADDR_W'(y_c) * ADDR_W'(row_len);
    assign lin  = prod + ADDR_W'(x_c);

    // Scale to bytes per pixel
    always_comb begin
        case (pixel_format)
            bpw_pkg::FMT_4BPP:  addr = lin >> 1;
            bpw_pkg::FMT_15BPP,
            bpw_pkg::FMT_16BPP: addr = {lin[ADDR_W-2:0], 1'b0};
            bpw_pkg::FMT_24BPP: addr = lin + {lin[ADDR_W-2:0], 1'b0};
            bpw_pkg::FMT_32BPP: addr = {lin[ADDR_W-3:0], 2'b00};
            default:            addr = lin;
        endcase
    end

    // Clamp the window shift to its legal range
    always_comb begin
        if (window_shift < bpw_pkg::WSHIFT_MIN) begin
            sh = bpw_pkg::WSHIFT_MIN;
        end else if (window_shift > bpw_pkg::WSHIFT_MAX) begin
            sh = bpw_pkg::WSHIFT_MAX;
        end else begin
            sh = window_shift;
        end
    end

    // Bank number and offset inside the window
    assign addr_shr        = addr >> sh;
    assign mask            = (MASK_W'(1) << sh) - MASK_W'(1);
    assign pix_addr.bank   = addr_shr[bpw_pkg::BANK_W-1:0];
    assign pix_addr.offset = addr[bpw_pkg::OFFS_W-1:0] & mask[bpw_pkg::OFFS_W-1:0];

endmodule

// File: hw/rtl/banked_pixel_writer_core.sv
`timescale 1ns / 1ps
// A result word passes from the input register through the result word register to m_tdata.
// One word per cycle while m_tready is high; the input register feeds the address multiply,
// the palette lookup and the window split, all in the single stage before the output register.
// Palette writes and pixels in an unused format give no result and never wait on the output.
// Reset (aresetn low, synchronous) clears both valid flags, loads the register defaults
// and zeroes all 16 palette entries at once; the block is ready right after reset.
// ----------------------------------------------------------------------------
// Banked pixel writer core
// Converts pixel writes into bank, window offset and store bytes for a
// banked framebuffer, and loads palette entries from palette write words.
// ----------------------------------------------------------------------------
module banked_pixel_writer_core #(
    parameter int COORD_BITS = bpw_pkg::COORD_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration write port
    input  logic                               cfg_wr_en,
    input  logic [bpw_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [bpw_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    // Input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // pos_x[11:0], pos_y[23:12], color[31:24], pal_index[35:32],
    // pal_red[41:36], pal_green[47:42], pal_blue[53:48], zero[55:54]
    input  logic [bpw_pkg::S_TDATA_W-1:0]      s_tdata,
    // opcode[0]
    input  logic                               s_tuser,
    // Result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // bank[15:0], offset[31:16], write_data[55:32], byte_count[57:56], zero[63:58]
    output logic [bpw_pkg::M_TDATA_W-1:0]      m_tdata
);

    logic [bpw_pkg::FMT_W-1:0]     fmt_reg;
    logic [bpw_pkg::WIDTH_W-1:0]   width_reg;
    logic [bpw_pkg::LINE_W-1:0]    line_reg;
    logic [bpw_pkg::WSHIFT_W-1:0]  wshift_reg;

    logic                          in_valid_reg, in_valid_next;
    logic [bpw_pkg::S_TDATA_W-1:0] in_data_reg;
    logic                          in_op_reg;
    logic                          out_valid_reg, out_valid_next;
    logic [bpw_pkg::M_TDATA_W-1:0] out_data_reg;

    logic                          in_has_result;
    logic                          out_load_ok;
    logic                          out_load;
    logic                          in_adv;
    logic                          s_accept;
    bpw_pkg::pal_wr_t              pal_wr;
    bpw_pkg::pix_data_t            pix_data;
    bpw_pkg::pix_addr_t            pix_addr;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg    <= bpw_pkg::FMT_RST;
            width_reg  <= bpw_pkg::WIDTH_RST;
            line_reg   <= bpw_pkg::LINE_RST;
            wshift_reg <= bpw_pkg::WSHIFT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                bpw_pkg::CFG_PIXEL_FORMAT: fmt_reg    <= cfg_wr_data[bpw_pkg::FMT_W-1:0];
                bpw_pkg::CFG_SCREEN_WIDTH: width_reg  <= cfg_wr_data[bpw_pkg::WIDTH_W-1:0];
                bpw_pkg::CFG_LINE_BYTES:   line_reg   <= cfg_wr_data[bpw_pkg::LINE_W-1:0];
                bpw_pkg::CFG_WINDOW_SHIFT: wshift_reg <= cfg_wr_data[bpw_pkg::WSHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake between the input register and the output register
    assign in_has_result = in_valid_reg && (in_op_reg == bpw_pkg::OP_PIXEL) &&
                           (fmt_reg <= bpw_pkg::FMT_LAST);
    assign out_load_ok   = !out_valid_reg || m_tready;
    assign out_load      = in_has_result && out_load_ok;
    assign in_adv        = in_valid_reg && (!in_has_result || out_load_ok);
    assign s_tready      = !in_valid_reg || in_adv;
    assign s_accept      = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (in_adv) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input word register
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_data_reg <= s_tdata;
            in_op_reg   <= s_tuser;
        end
    end

    // Palette entry write when a palette word leaves the input register
    assign pal_wr.en    = in_adv && (in_op_reg == bpw_pkg::OP_PALETTE);
    assign pal_wr.idx   = in_data_reg[35:32];
    assign pal_wr.entry = {in_data_reg[41:36], in_data_reg[47:42], in_data_reg[53:48]};

    bpw_palette u_palette (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .pal_wr       (pal_wr),
        .color        (in_data_reg[31:24]),
        .pixel_format (fmt_reg),
        .pix_data     (pix_data)
    );

    bpw_addr #(
        .COORD_BITS (COORD_BITS)
    ) u_addr (
        .pos_x        (in_data_reg[11:0]),
        .pos_y        (in_data_reg[23:12]),
        .pixel_format (fmt_reg),
        .screen_width (width_reg),
        .line_bytes   (line_reg),
        .window_shift (wshift_reg),
        .pix_addr     (pix_addr)
    );

    // Result word register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= {6'd0, pix_data.count, pix_data.data,
                             pix_addr.offset, pix_addr.bank};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // A palette word never loads a result
    a_pal_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pal_wr.en && out_load))
        else $error("palette write loaded a result word");

    // A valid result always stores at least one byte
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[57:56] != 2'd0))
        else $error("result word with zero byte count");

    // Input stalls only behind a full, stalled output with a pixel waiting
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_has_result && out_valid_reg && !m_tready))
        else $error("input stalled without a stalled result");

    // An accepted pixel that can move reaches the output register next cycle
    a_pixel_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_tvalid)
        else $error("loaded result not presented");

endmodule
